@@ hw/rtl/wall_evidence_accumulator_top_macros.svh @@
// Assertion macros for the wall evidence accumulator.
`ifndef WALL_EVIDENCE_ACCUMULATOR_TOP_MACROS_SVH
`define WALL_EVIDENCE_ACCUMULATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define WEA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wall evidence accumulator check failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define WEA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wall evidence accumulator check failed");
`else
`define WEA_ASSERT_NOW(lbl, ante, cons)
`define WEA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ hw/rtl/wea_pkg.sv @@
// Shared types and constants for the wall evidence accumulator.
package wea_pkg;

    localparam int WEIGHT_WIDTH    = 16;
    localparam int CFG_INDEX_WIDTH = 3;

    typedef logic [WEIGHT_WIDTH-1:0] weight_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_HIT_WEIGHT        = 3'd0,
        CFG_MISS_WEIGHT       = 3'd1,
        CFG_DECAY_STEP        = 3'd2,
        CFG_TRANSITION_WEIGHT = 3'd3,
        CFG_COMMIT_THRESHOLD  = 3'd4
    } cfg_reg_t;

    localparam weight_t HIT_WEIGHT_RESET        = 16'd256;
    localparam weight_t MISS_WEIGHT_RESET       = 16'd256;
    localparam weight_t DECAY_STEP_RESET        = 16'd64;
    localparam weight_t TRANSITION_WEIGHT_RESET = 16'd512;
    localparam weight_t COMMIT_THRESHOLD_RESET  = 16'd512;

    typedef struct packed {
        logic front_valid;
        logic front_wall;
        logic front_left_wall;
        logic front_right_wall;
        logic left_window_valid;
        logic left_wall;
        logic left_transition;
        logic right_window_valid;
        logic right_wall;
        logic right_transition;
        logic last_sample;
    } sample_t;

    typedef struct packed {
        logic front_present;
        logic front_decided;
        logic front_left_majority;
        logic front_right_majority;
        logic left_present;
        logic left_decided;
        logic right_present;
        logic right_decided;
        logic left_edge_seen;
        logic right_edge_seen;
    } result_t;

endpackage

@@ hw/rtl/wall_evidence_accumulator_top.sv @@
// Wall evidence accumulator: per-beat score update, commit decision on the last beat.
// A last_sample input beat passes the input register, then the result register, which presents its result beat.
// Throughput: one input beat per cycle; only a last_sample beat can stall the input, and only
// while the result register still holds a result beat that has not been taken.
// Reset: asynchronous, active low; clears scores, counters, edge flags and valids, and
// loads the configuration registers with their default weights.
`include "wall_evidence_accumulator_top_macros.svh"

module wall_evidence_accumulator_top #(
    parameter int SCORE_WIDTH = 24,
    parameter int COUNT_WIDTH = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [wea_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [wea_pkg::WEIGHT_WIDTH-1:0]     cfg_data,

    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 front_valid,
    input  logic                                 front_wall,
    input  logic                                 front_left_wall,
    input  logic                                 front_right_wall,
    input  logic                                 left_window_valid,
    input  logic                                 left_wall,
    input  logic                                 left_transition,
    input  logic                                 right_window_valid,
    input  logic                                 right_wall,
    input  logic                                 right_transition,
    input  logic                                 last_sample,

    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 front_present,
    output logic                                 front_decided,
    output logic                                 front_left_majority,
    output logic                                 front_right_majority,
    output logic                                 left_present,
    output logic                                 left_decided,
    output logic                                 right_present,
    output logic                                 right_decided,
    output logic                                 left_edge_seen,
    output logic                                 right_edge_seen
);

    localparam int EXT_WIDTH = SCORE_WIDTH + 2;

    typedef logic signed [SCORE_WIDTH-1:0] score_t;
    typedef logic signed [EXT_WIDTH-1:0]   ext_t;
    typedef logic [COUNT_WIDTH-1:0]        count_t;

    localparam ext_t SCORE_MAX_E = ext_t'({1'b0, {(SCORE_WIDTH-1){1'b1}}});
    localparam ext_t SCORE_MIN_E = -SCORE_MAX_E - ext_t'(1);

    function automatic score_t sat_score(input ext_t v);
        score_t r;
        if (v > SCORE_MAX_E) begin
            r = score_t'(SCORE_MAX_E);
        end
        else if (v < SCORE_MIN_E) begin
            r = score_t'(SCORE_MIN_E);
        end
        else begin
            r = score_t'(v);
        end
        return r;
    endfunction

    function automatic count_t count_up(input count_t c);
        count_t r;
        r = (c == {COUNT_WIDTH{1'b1}}) ? c : c + count_t'(1);
        return r;
    endfunction

    // Hit adds, miss subtracts, an invalid sample decays toward zero without crossing it.
    function automatic score_t evidence(input score_t s, input logic valid, input logic hit,
                                        input wea_pkg::weight_t hit_w,
                                        input wea_pkg::weight_t miss_w,
                                        input wea_pkg::weight_t decay);
        ext_t   se;
        ext_t   moved;
        score_t r;
        se = ext_t'(s);
        if (valid) begin
            if (hit) begin
                r = sat_score(se + ext_t'(hit_w));
            end
            else begin
                r = sat_score(se - ext_t'(miss_w));
            end
        end
        else if (se > ext_t'(0)) begin
            moved = se - ext_t'(decay);
            r = (moved > ext_t'(0)) ? score_t'(moved) : score_t'(0);
        end
        else begin
            moved = se + ext_t'(decay);
            r = (moved < ext_t'(0)) ? score_t'(moved) : score_t'(0);
        end
        return r;
    endfunction

    function automatic logic [1:0] decide(input score_t s, input wea_pkg::weight_t thr);
        ext_t se;
        ext_t te;
        logic present;
        logic decided;
        se = ext_t'(s);
        te = ext_t'(thr);
        present = (thr != '0) && (se >= te);
        decided = (thr != '0) && ((se >= te) || (se <= -te));
        return {present, decided};
    endfunction

    function automatic logic majority(input count_t votes, input count_t count);
        return (count != '0) && (votes > (count >> 1));
    endfunction

    // Configuration registers.
    wea_pkg::weight_t hit_weight_reg;
    wea_pkg::weight_t miss_weight_reg;
    wea_pkg::weight_t decay_step_reg;
    wea_pkg::weight_t transition_weight_reg;
    wea_pkg::weight_t commit_threshold_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_weight_reg        <= wea_pkg::HIT_WEIGHT_RESET;
            miss_weight_reg       <= wea_pkg::MISS_WEIGHT_RESET;
            decay_step_reg        <= wea_pkg::DECAY_STEP_RESET;
            transition_weight_reg <= wea_pkg::TRANSITION_WEIGHT_RESET;
            commit_threshold_reg  <= wea_pkg::COMMIT_THRESHOLD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (wea_pkg::cfg_reg_t'(cfg_index))
                wea_pkg::CFG_HIT_WEIGHT:        hit_weight_reg        <= cfg_data;
                wea_pkg::CFG_MISS_WEIGHT:       miss_weight_reg       <= cfg_data;
                wea_pkg::CFG_DECAY_STEP:        decay_step_reg        <= cfg_data;
                wea_pkg::CFG_TRANSITION_WEIGHT: transition_weight_reg <= cfg_data;
                wea_pkg::CFG_COMMIT_THRESHOLD:  commit_threshold_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register.
    logic             s1_valid_reg;
    wea_pkg::sample_t s1_reg;
    logic             s1_go;
    logic             out_free;

    assign out_free = !out_valid || !out_stall;
    assign s1_go    = s1_valid_reg && (!s1_reg.last_sample || out_free);
    assign in_stall = s1_valid_reg && !s1_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_reg <= '{front_valid:        front_valid,
                        front_wall:         front_wall,
                        front_left_wall:    front_left_wall,
                        front_right_wall:   front_right_wall,
                        left_window_valid:  left_window_valid,
                        left_wall:          left_wall,
                        left_transition:    left_transition,
                        right_window_valid: right_window_valid,
                        right_wall:         right_wall,
                        right_transition:   right_transition,
                        last_sample:        last_sample};
        end
    end

    // Evidence state and its update.
    score_t front_score_reg, front_score_next;
    score_t left_score_reg,  left_score_next;
    score_t right_score_reg, right_score_next;
    count_t front_count_reg, front_count_next;
    count_t fl_votes_reg,    fl_votes_next;
    count_t fr_votes_reg,    fr_votes_next;
    logic   left_edge_reg,   left_edge_next;
    logic   right_edge_reg,  right_edge_next;
    score_t left_upd;
    score_t right_upd;
    logic [1:0] front_dec;
    logic [1:0] left_dec;
    logic [1:0] right_dec;
    wea_pkg::result_t result_next;

    always_comb
    begin
        front_count_next = front_count_reg;
        fl_votes_next    = fl_votes_reg;
        fr_votes_next    = fr_votes_reg;
        if (s1_reg.front_valid)
        begin
            front_count_next = count_up(front_count_reg);
            if (s1_reg.front_left_wall)
            begin
                fl_votes_next = count_up(fl_votes_reg);
            end
            if (s1_reg.front_right_wall)
            begin
                fr_votes_next = count_up(fr_votes_reg);
            end
        end

        front_score_next = evidence(front_score_reg, s1_reg.front_valid, s1_reg.front_wall,
                                    hit_weight_reg, miss_weight_reg, decay_step_reg);
        left_upd = evidence(left_score_reg, s1_reg.left_window_valid, s1_reg.left_wall,
                            hit_weight_reg, miss_weight_reg, decay_step_reg);
        right_upd = evidence(right_score_reg, s1_reg.right_window_valid, s1_reg.right_wall,
                             hit_weight_reg, miss_weight_reg, decay_step_reg);

        // A side transition adds a further miss impulse after the regular update.
        left_score_next = s1_reg.left_transition
            ? sat_score(ext_t'(left_upd) - ext_t'(transition_weight_reg)) : left_upd;
        right_score_next = s1_reg.right_transition
            ? sat_score(ext_t'(right_upd) - ext_t'(transition_weight_reg)) : right_upd;
        left_edge_next  = left_edge_reg  || s1_reg.left_transition;
        right_edge_next = right_edge_reg || s1_reg.right_transition;

        front_dec = decide(front_score_next, commit_threshold_reg);
        left_dec  = decide(left_score_next, commit_threshold_reg);
        right_dec = decide(right_score_next, commit_threshold_reg);

        result_next.front_present        = front_dec[1];
        result_next.front_decided        = front_dec[0];
        result_next.front_left_majority  = majority(fl_votes_next, front_count_next);
        result_next.front_right_majority = majority(fr_votes_next, front_count_next);
        result_next.left_present         = left_dec[1];
        result_next.left_decided         = left_dec[0];
        result_next.right_present        = right_dec[1];
        result_next.right_decided        = right_dec[0];
        result_next.left_edge_seen       = left_edge_next;
        result_next.right_edge_seen      = right_edge_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_score_reg <= '0;
            left_score_reg  <= '0;
            right_score_reg <= '0;
            front_count_reg <= '0;
            fl_votes_reg    <= '0;
            fr_votes_reg    <= '0;
            left_edge_reg   <= 1'b0;
            right_edge_reg  <= 1'b0;
        end
        else if (s1_go)
        begin
            if (s1_reg.last_sample)
            begin
                // The burst ends here: its decisions go to the result register.
                front_score_reg <= '0;
                left_score_reg  <= '0;
                right_score_reg <= '0;
                front_count_reg <= '0;
                fl_votes_reg    <= '0;
                fr_votes_reg    <= '0;
                left_edge_reg   <= 1'b0;
                right_edge_reg  <= 1'b0;
            end
            else
            begin
                front_score_reg <= front_score_next;
                left_score_reg  <= left_score_next;
                right_score_reg <= right_score_next;
                front_count_reg <= front_count_next;
                fl_votes_reg    <= fl_votes_next;
                fr_votes_reg    <= fr_votes_next;
                left_edge_reg   <= left_edge_next;
                right_edge_reg  <= right_edge_next;
            end
        end
    end

    // Result register.
    logic             out_valid_reg;
    wea_pkg::result_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go && s1_reg.last_sample)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_reg.last_sample)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid            = out_valid_reg;
    assign front_present        = result_reg.front_present;
    assign front_decided        = result_reg.front_decided;
    assign front_left_majority  = result_reg.front_left_majority;
    assign front_right_majority = result_reg.front_right_majority;
    assign left_present         = result_reg.left_present;
    assign left_decided         = result_reg.left_decided;
    assign right_present        = result_reg.right_present;
    assign right_decided        = result_reg.right_decided;
    assign left_edge_seen       = result_reg.left_edge_seen;
    assign right_edge_seen      = result_reg.right_edge_seen;

    logic present_ok;
    logic none_decided;
    logic state_cleared;
    logic votes_ok;
    logic last_go;

    assign present_ok    = (!result_reg.front_present || result_reg.front_decided)
                        && (!result_reg.left_present || result_reg.left_decided)
                        && (!result_reg.right_present || result_reg.right_decided);
    assign none_decided  = !result_reg.front_decided && !result_reg.left_decided
                        && !result_reg.right_decided;
    assign state_cleared = (front_score_reg == '0) && (left_score_reg == '0)
                        && (right_score_reg == '0) && (front_count_reg == '0)
                        && !left_edge_reg && !right_edge_reg;
    assign votes_ok      = (fl_votes_reg <= front_count_reg) && (fr_votes_reg <= front_count_reg);
    assign last_go       = s1_go && s1_reg.last_sample;

    // A committed wall is always a decided wall.
    `WEA_ASSERT_NOW(a_present_implies_decided, out_valid_reg, present_ok)
    // A zero threshold leaves every decision unknown.
    `WEA_ASSERT_NEXT(a_zero_threshold_unknown, last_go && (commit_threshold_reg == '0), none_decided)
    // The last beat of a burst leaves the evidence state cleared.
    `WEA_ASSERT_NEXT(a_clear_after_last, last_go, state_cleared)
    // Votes can never outnumber the valid front samples.
    `WEA_ASSERT_NOW(a_votes_bounded, 1'b1, votes_ok)

endmodule

@@ test/wall_evidence_checker.sv @@
// Checker for the wall evidence accumulator: predicts each commit report and compares it.
module wall_evidence_checker #(
    parameter int SCORE_WIDTH = 24,
    parameter int COUNT_WIDTH = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [wea_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wea_pkg::weight_t                    cfg_data,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  wea_pkg::sample_t                    in_beat,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  wea_pkg::result_t                    out_beat,
    output int                                  fail_count,
    output int                                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SCORE_MAX = (longint'(1) <<< (SCORE_WIDTH - 1)) - 1;
    localparam longint SCORE_MIN = -SCORE_MAX - 1;

    typedef logic signed [SCORE_WIDTH-1:0] score_t;
    typedef logic [COUNT_WIDTH-1:0]        count_t;

    wea_pkg::weight_t hit_w;
    wea_pkg::weight_t miss_w;
    wea_pkg::weight_t decay_w;
    wea_pkg::weight_t edge_w;
    wea_pkg::weight_t commit_w;

    score_t  front_score;
    score_t  left_score;
    score_t  right_score;
    count_t  front_samples;
    count_t  fl_votes;
    count_t  fr_votes;
    logic    left_edge;
    logic    right_edge;

    wea_pkg::result_t due_reports[$];

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic score_t clip(input longint v);
        if (v > SCORE_MAX)
            return score_t'(SCORE_MAX);
        if (v < SCORE_MIN)
            return score_t'(SCORE_MIN);
        return score_t'(v);
    endfunction

    // A valid hit or miss moves the score by its weight; otherwise it decays toward zero.
    function automatic score_t weigh(input score_t s, input logic seen, input logic hit);
        longint cur;
        cur = longint'(s);
        if (seen)
            return hit ? clip(cur + longint'(hit_w)) : clip(cur - longint'(miss_w));
        if (cur > 0)
            return (cur > longint'(decay_w)) ? score_t'(cur - longint'(decay_w)) : score_t'(0);
        if (cur < 0)
            return (-cur > longint'(decay_w)) ? score_t'(cur + longint'(decay_w)) : score_t'(0);
        return score_t'(0);
    endfunction

    // Returns {present, decided}; a zero threshold never commits.
    function automatic logic [1:0] commit(input score_t s);
        longint cur;
        longint t;
        cur = longint'(s);
        t   = longint'(commit_w);
        if (t == 0)
            return 2'b00;
        if (cur >= t)
            return 2'b11;
        if (cur <= -t)
            return 2'b01;
        return 2'b00;
    endfunction

    function automatic logic majority(input count_t votes, input count_t total);
        return (total != 0) && (int'(votes) >= int'(total) / 2 + 1);
    endfunction

    function automatic count_t bump(input count_t c);
        return (&c) ? c : c + 1'b1;
    endfunction

    task automatic clear_burst();
        front_score   = '0;
        left_score    = '0;
        right_score   = '0;
        front_samples = '0;
        fl_votes      = '0;
        fr_votes      = '0;
        left_edge     = 1'b0;
        right_edge    = 1'b0;
    endtask

    task automatic absorb_sample(input wea_pkg::sample_t s);
        wea_pkg::result_t r;
        logic [1:0]       fd;
        logic [1:0]       ld;
        logic [1:0]       rd;
        if (s.front_valid)
        begin
            front_samples = bump(front_samples);
            if (s.front_left_wall)
                fl_votes = bump(fl_votes);
            if (s.front_right_wall)
                fr_votes = bump(fr_votes);
        end
        front_score = weigh(front_score, s.front_valid, s.front_wall);

        left_score = weigh(left_score, s.left_window_valid, s.left_wall);
        if (s.left_transition)
        begin
            left_edge  = 1'b1;
            left_score = clip(longint'(left_score) - longint'(edge_w));
        end

        right_score = weigh(right_score, s.right_window_valid, s.right_wall);
        if (s.right_transition)
        begin
            right_edge  = 1'b1;
            right_score = clip(longint'(right_score) - longint'(edge_w));
        end

        if (s.last_sample)
        begin
            fd = commit(front_score);
            ld = commit(left_score);
            rd = commit(right_score);
            r.front_present        = fd[1];
            r.front_decided        = fd[0];
            r.front_left_majority  = majority(fl_votes, front_samples);
            r.front_right_majority = majority(fr_votes, front_samples);
            r.left_present         = ld[1];
            r.left_decided         = ld[0];
            r.right_present        = rd[1];
            r.right_decided        = rd[0];
            r.left_edge_seen       = left_edge;
            r.right_edge_seen      = right_edge;
            due_reports.push_back(r);
            clear_burst();
        end
    endtask

    task automatic check_flag(input string name, input logic want, input logic got);
        if (got !== want)
        begin
            fail_count++;
            $display("%0t: %s expected %b actual %b", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        wea_pkg::result_t want;
        if (!rst_n)
        begin
            hit_w    = wea_pkg::HIT_WEIGHT_RESET;
            miss_w   = wea_pkg::MISS_WEIGHT_RESET;
            decay_w  = wea_pkg::DECAY_STEP_RESET;
            edge_w   = wea_pkg::TRANSITION_WEIGHT_RESET;
            commit_w = wea_pkg::COMMIT_THRESHOLD_RESET;
            clear_burst();
            due_reports.delete();
        end
        else
        begin
            // A report leaves only after its last beat has passed the input register and the result
            // register, so compare before predicting.
            if (out_valid && !out_stall)
            begin
                if (due_reports.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: report beat expected none actual %b", $time, out_beat);
                end
                else
                begin
                    want = due_reports.pop_front();
                    check_flag("front_present", want.front_present, out_beat.front_present);
                    check_flag("front_decided", want.front_decided, out_beat.front_decided);
                    check_flag("front_left_majority", want.front_left_majority,
                               out_beat.front_left_majority);
                    check_flag("front_right_majority", want.front_right_majority,
                               out_beat.front_right_majority);
                    check_flag("left_present", want.left_present, out_beat.left_present);
                    check_flag("left_decided", want.left_decided, out_beat.left_decided);
                    check_flag("right_present", want.right_present, out_beat.right_present);
                    check_flag("right_decided", want.right_decided, out_beat.right_decided);
                    check_flag("left_edge_seen", want.left_edge_seen, out_beat.left_edge_seen);
                    check_flag("right_edge_seen", want.right_edge_seen,
                               out_beat.right_edge_seen);
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    wea_pkg::CFG_HIT_WEIGHT:        hit_w    = cfg_data;
                    wea_pkg::CFG_MISS_WEIGHT:       miss_w   = cfg_data;
                    wea_pkg::CFG_DECAY_STEP:        decay_w  = cfg_data;
                    wea_pkg::CFG_TRANSITION_WEIGHT: edge_w   = cfg_data;
                    wea_pkg::CFG_COMMIT_THRESHOLD:  commit_w = cfg_data;
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
                absorb_sample(in_beat);
        end
        pending = due_reports.size();
    end

endmodule

@@ test/wall_evidence_accumulator_top_tb.sv @@
// Stimulus and verdict for the wall evidence accumulator, with the checker beside the block.
module wall_evidence_accumulator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SCORE_W        = 24;
    localparam int COUNT_W        = 8;
    localparam int ITEM_TARGET    = 1100;
    localparam int CALM_TAIL      = 120;
    localparam int SETTLE_CYCLES  = 4;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int DIRECTED_COUNT = 19;
    localparam logic [wea_pkg::CFG_INDEX_WIDTH-1:0] CFG_SPARE_BASE = 3'd5;

    logic                                clk;
    logic                                rst_n;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [wea_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
    wea_pkg::weight_t                    cfg_data;
    logic                                in_valid;
    logic                                in_stall;
    wea_pkg::sample_t                    stim;
    logic                                out_valid;
    logic                                out_stall;
    logic                                front_present;
    logic                                front_decided;
    logic                                front_left_majority;
    logic                                front_right_majority;
    logic                                left_present;
    logic                                left_decided;
    logic                                right_present;
    logic                                right_decided;
    logic                                left_edge_seen;
    logic                                right_edge_seen;
    wea_pkg::result_t                    report_beat;

    int fail_count;
    int pending;
    int sent;
    int free_run;
    int cycle_count;
    bit calm;

    assign report_beat = {front_present, front_decided, front_left_majority,
                          front_right_majority, left_present, left_decided,
                          right_present, right_decided, left_edge_seen, right_edge_seen};

    wall_evidence_accumulator_top #(
        .SCORE_WIDTH (SCORE_W),
        .COUNT_WIDTH (COUNT_W)
    ) dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .in_valid             (in_valid),
        .in_stall             (in_stall),
        .front_valid          (stim.front_valid),
        .front_wall           (stim.front_wall),
        .front_left_wall      (stim.front_left_wall),
        .front_right_wall     (stim.front_right_wall),
        .left_window_valid    (stim.left_window_valid),
        .left_wall            (stim.left_wall),
        .left_transition      (stim.left_transition),
        .right_window_valid   (stim.right_window_valid),
        .right_wall           (stim.right_wall),
        .right_transition     (stim.right_transition),
        .last_sample          (stim.last_sample),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .front_present        (front_present),
        .front_decided        (front_decided),
        .front_left_majority  (front_left_majority),
        .front_right_majority (front_right_majority),
        .left_present         (left_present),
        .left_decided         (left_decided),
        .right_present        (right_present),
        .right_decided        (right_decided),
        .left_edge_seen       (left_edge_seen),
        .right_edge_seen      (right_edge_seen)
    );

    wall_evidence_checker #(
        .SCORE_WIDTH (SCORE_W),
        .COUNT_WIDTH (COUNT_W)
    ) checker_inst (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_beat    (stim),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_beat   (report_beat),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Report backpressure alternates stall bursts with free stretches until the tail.
    initial
    begin : report_backpressure
        int stall_left;
        int free_left;
        out_stall  = 1'b0;
        stall_left = 0;
        free_left  = 0;
        forever
        begin
            @(negedge clk);
            if (!calm && stall_left == 0 && free_left == 0)
            begin
                if ($urandom_range(0, 1) == 0)
                    stall_left = $urandom_range(1, 12);
                else
                    free_left = $urandom_range(1, 30);
            end
            if (calm)
                out_stall <= 1'b0;
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                free_left--;
            end
        end
    end

    // Bit order: front valid, wall, left, right | left valid, wall, edge |
    // right valid, wall, edge | last.
    function automatic wea_pkg::sample_t directed_item(input int k);
        case (k)
            0:       return 11'b0000_000_000_1;
            1:       return 11'b1111_110_100_0;
            2:       return 11'b1111_110_101_0;
            3:       return 11'b1101_111_100_0;
            4:       return 11'b1000_000_000_0;
            5:       return 11'b0000_000_000_0;
            6:       return 11'b1111_110_110_1;
            7:       return 11'b1111_111_111_1;
            8:       return 11'b1100_110_110_0;
            14:      return 11'b1000_100_100_0;
            16:      return 11'b0011_001_001_1;
            17:      return 11'b1010_100_100_0;
            18:      return 11'b1001_100_100_1;
            default: return 11'b0000_000_000_0;
        endcase
    endfunction

    function automatic int sender_gap();
        if (calm)
            return 0;
        if (free_run > 0)
        begin
            free_run--;
            return 0;
        end
        if ($urandom_range(0, 2) == 0)
            return $urandom_range(1, 12);
        free_run = $urandom_range(4, 40);
        return 0;
    endfunction

    function automatic wea_pkg::weight_t pick_weight();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return 16'd1;
            3:       return wea_pkg::weight_t'($urandom_range(1, 1023));
            4:       return wea_pkg::weight_t'($urandom_range(0, 65535));
            default: return 16'd256;
        endcase
    endfunction

    function automatic logic lean(input logic bias);
        return ($urandom_range(0, 7) == 0) ? ~bias : bias;
    endfunction

    task automatic push_sample(input wea_pkg::sample_t s);
        int gap;
        gap = sender_gap();
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        stim     <= s;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Holds the sender off until every report has come and the pipeline is empty.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [wea_pkg::CFG_INDEX_WIDTH-1:0] idx,
                             input wea_pkg::weight_t val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input wea_pkg::weight_t hit, input wea_pkg::weight_t miss,
                             input wea_pkg::weight_t decay, input wea_pkg::weight_t trans,
                             input wea_pkg::weight_t thr);
        logic [wea_pkg::CFG_INDEX_WIDTH-1:0] spare;
        write_reg(wea_pkg::CFG_HIT_WEIGHT, hit);
        write_reg(wea_pkg::CFG_MISS_WEIGHT, miss);
        write_reg(wea_pkg::CFG_DECAY_STEP, decay);
        write_reg(wea_pkg::CFG_TRANSITION_WEIGHT, trans);
        write_reg(wea_pkg::CFG_COMMIT_THRESHOLD, thr);
        // Unmapped indexes must leave every register untouched.
        if ($urandom_range(0, 2) == 0)
        begin
            spare = CFG_SPARE_BASE + 3'($urandom_range(0, 2));
            write_reg(spare, wea_pkg::weight_t'($urandom_range(0, 65535)));
        end
    endtask

    // Mostly coherent bursts that lean toward one answer per sensor, with some noise beats.
    task automatic run_burst(input bit lengthy);
        int               len;
        wea_pkg::sample_t s;
        logic             fw;
        logic             fl;
        logic             fr;
        logic             lw;
        logic             rw;
        len = lengthy ? $urandom_range(280, 400) : $urandom_range(1, 12);
        fw  = 1'($urandom_range(0, 1));
        fl  = 1'($urandom_range(0, 1));
        fr  = 1'($urandom_range(0, 1));
        lw  = 1'($urandom_range(0, 1));
        rw  = 1'($urandom_range(0, 1));
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                s = wea_pkg::sample_t'($urandom_range(0, 2047));
            else
            begin
                s.front_valid        = lengthy ? 1'b1 : ($urandom_range(0, 3) != 0);
                s.front_wall         = lean(fw);
                s.front_left_wall    = lean(fl);
                s.front_right_wall   = lean(fr);
                s.left_window_valid  = ($urandom_range(0, 3) != 0);
                s.left_wall          = lean(lw);
                s.left_transition    = ($urandom_range(0, 7) == 0);
                s.right_window_valid = ($urandom_range(0, 3) != 0);
                s.right_wall         = lean(rw);
                s.right_transition   = ($urandom_range(0, 7) == 0);
                s.last_sample        = 1'b0;
            end
            if (i == len - 1)
                s.last_sample = 1'b1;
            push_sample(s);
            sent++;
            calm = (sent >= ITEM_TARGET - CALM_TAIL);
        end
    endtask

    initial
    begin : stimulus
        int phase;
        int bursts;
        in_valid  = 1'b0;
        stim      = '0;
        cfg_valid = 1'b0;
        cfg_index = wea_pkg::CFG_HIT_WEIGHT;
        cfg_data  = '0;
        rst_n     = 1'b0;
        calm      = 1'b0;
        sent      = 0;
        free_run  = 0;
        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int k = 0; k < DIRECTED_COUNT; k++)
            push_sample(directed_item(k));

        phase = 0;
        while (sent < ITEM_TARGET)
        begin
            settle();
            case (phase)
                0:       configure('0, '0, '0, '0, '0);
                1:       configure('1, '1, '1, '1, '1);
                2:       configure(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
                default: configure(pick_weight(), pick_weight(), pick_weight(),
                                   pick_weight(), pick_weight());
            endcase
            // The full-scale phase runs one long burst to drive scores and counters to saturation.
            bursts = (phase == 1) ? 1 : $urandom_range(1, 6);
            for (int b = 0; b < bursts && sent < ITEM_TARGET; b++)
            begin
                run_burst(phase == 1);
                if (!calm && $urandom_range(0, 7) == 0)
                    settle();
            end
            phase++;
        end

        settle();
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/wea_pkg.sv
hw/rtl/wall_evidence_accumulator_top.sv
test/wall_evidence_checker.sv
test/wall_evidence_accumulator_top_tb.sv
